// File: hw/rtl/page_framebuffer_draw_engine_assert.svh
// ----------------------------------------------------------------------------
// Draw engine assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// same-cycle implication
`define PFDE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pfde_pkg.sv
// ----------------------------------------------------------------------------
// Draw engine package
// Command codes, controller states and arithmetic constants.
// ----------------------------------------------------------------------------
package pfde_pkg;

	localparam int DEF_SCREEN_COLUMNS = 128;
	localparam int DEF_SCREEN_ROWS    = 64;

	localparam int ACTION_W = 3;
	localparam int COORD_W  = 8;
	localparam int INDEX_W  = 10;
	localparam int PCT_W    = 8;
	localparam int DATA_W   = 8;

	localparam int PCT_MAX     = 100;
	localparam int BAR_MIN     = 4;
	// floor(p / 100) == (p * RECIP) >> RECIP_SHIFT for p below 25300
	localparam int RECIP       = 20972;
	localparam int RECIP_SHIFT = 21;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SET  = 3'd0,
		ACT_RECT = 3'd1,
		ACT_BAR  = 3'd2,
		ACT_FILL = 3'd3,
		ACT_READ = 3'd4
	} action_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_SCALE,
		ST_SWEEP,
		ST_FINISH,
		ST_RDOUT
	} state_e_t;

	// v lies in the wrapped span [s, s+n)
	function automatic logic in_span(input logic [7:0] v, input logic [7:0] s,
			input logic [7:0] n);
		logic [7:0] d;
		d = v - s;
		return d < n;
	endfunction

endpackage

// File: hw/rtl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// Page framebuffer draw engine
// Set pixel: one-byte read-modify-write; off-screen pixel: result from idle.
// Rectangle and fill all: one read-modify-write sweep of the store, one byte
//   a cycle; bar first passes through the calc and scale states.
// Read byte: via read-out; unused codes, bars under BAR_MIN: from idle.
// Busy falls with the result. Reset: busy stays high through a clearing pass.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
	parameter int SCREEN_COLUMNS = pfde_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = pfde_pkg::DEF_SCREEN_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pfde_pkg::ACTION_W-1:0] action,
	input  logic [pfde_pkg::COORD_W-1:0]  x,
	input  logic [pfde_pkg::COORD_W-1:0]  y,
	input  logic [pfde_pkg::COORD_W-1:0]  width,
	input  logic [pfde_pkg::COORD_W-1:0]  height,
	input  logic                          on,
	input  logic signed [pfde_pkg::PCT_W-1:0] percent,
	input  logic [pfde_pkg::INDEX_W-1:0]  byte_index,
	output logic                          done,
	output logic [pfde_pkg::DATA_W-1:0]   byte_data
);
	import pfde_pkg::*;

	localparam int PAGES       = (SCREEN_ROWS + 7) / 8;
	localparam int STORE_BYTES = SCREEN_COLUMNS * PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int COL_W       = $clog2(SCREEN_COLUMNS);
	localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

	state_e_t state_q, state_d;

	action_e_t        act_q;
	logic [7:0]       x_q, y_q, w_q, h_q;
	logic             on_q;
	logic [6:0]       pct_q;
	logic             rd_ok_q;
	logic             clr_q;
	logic             one_q;
	logic [14:0]      prod_q;
	logic [7:0]       fill_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COL_W-1:0]  col_q;
	logic [PAGE_W-1:0] page_q;

	logic              valid_s1;
	logic              full_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0] wr_data;

	logic       done_q, done_d;
	logic [7:0] byte_data_q, data_d;

	logic       accept;
	logic       pix_ok, bar_ok, sweep_last;
	logic [6:0] pct_clamped;
	logic [7:0] sweep_mask;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign byte_data = byte_data_q;

	assign pix_ok = ({1'b0, x} < 9'(SCREEN_COLUMNS)) && ({1'b0, y} < 9'(SCREEN_ROWS));
	assign bar_ok = (width >= 8'(BAR_MIN)) && (height >= 8'(BAR_MIN));
	assign sweep_last = one_q || (addr_q == ADDR_W'(STORE_BYTES - 1));
	assign pct_clamped = percent[7] ? 7'd0 :
		((percent[6:0] > 7'(PCT_MAX)) ? 7'(PCT_MAX) : percent[6:0]);

	function automatic logic pix_hit(input logic [7:0] c, input logic [7:0] r);
		logic rect_hit, edge_hit, fill_hit;
		rect_hit = in_span(c, x_q, w_q) && in_span(r, y_q, h_q);
		edge_hit = (in_span(c, x_q, w_q) &&
				((r == y_q) || (r == 8'(y_q + h_q - 8'd1)))) ||
			(in_span(r, y_q, h_q) &&
				((c == x_q) || (c == 8'(x_q + w_q - 8'd1))));
		fill_hit = in_span(c, 8'(x_q + 8'd1), fill_q) &&
			in_span(r, 8'(y_q + 8'd1), 8'(h_q - 8'd2));
		return (act_q == ACT_BAR) ? (edge_hit || fill_hit) : rect_hit;
	endfunction

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			sweep_mask[k] = ({1'b0, 8'({page_q, 3'(k)})} < 9'(SCREEN_ROWS)) &&
				pix_hit(8'(col_q), 8'({page_q, 3'(k)}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		data_d  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_SET: begin
							state_d = pix_ok ? ST_SWEEP : ST_IDLE;
							done_d  = !pix_ok;
						end
						ACT_RECT: state_d = ST_SWEEP;
						ACT_BAR: begin
							state_d = bar_ok ? ST_CALC : ST_IDLE;
							done_d  = !bar_ok;
						end
						ACT_FILL: state_d = ST_SWEEP;
						ACT_READ: state_d = ST_RDOUT;
						default: done_d = 1'b1;
					endcase
				end
			end
			ST_CALC:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_SWEEP;
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
				done_d  = !clr_q;
			end
			ST_RDOUT: begin
				state_d = ST_IDLE;
				done_d  = 1'b1;
				data_d  = rd_ok_q ? rdata_q : 8'd0;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= ACT_FILL;
			on_q        <= 1'b0;
			clr_q       <= 1'b1;
			one_q       <= 1'b0;
			addr_q      <= '0;
			col_q       <= '0;
			page_q      <= '0;
			valid_s1    <= 1'b0;
			done_q      <= 1'b0;
			byte_data_q <= '0;
		end else begin
			done_q      <= done_d;
			byte_data_q <= data_d;
			valid_s1    <= (state_q == ST_SWEEP);
			if (accept) begin
				act_q   <= action_e_t'(action);
				clr_q   <= 1'b0;
				one_q   <= (action == ACT_SET);
				on_q    <= (action == ACT_BAR) ? 1'b1 : on;
				if (action == ACT_SET) begin
					col_q  <= COL_W'(x);
					page_q <= PAGE_W'(y[7:3]);
					addr_q <= ADDR_W'(int'(y[7:3]) * SCREEN_COLUMNS + int'(x));
				end else begin
					col_q  <= '0;
					page_q <= '0;
					addr_q <= '0;
				end
			end else if (state_q == ST_SWEEP) begin
				addr_q <= addr_q + 1'b1;
				if (col_q == COL_W'(SCREEN_COLUMNS - 1)) begin
					col_q  <= '0;
					page_q <= page_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x;
			y_q     <= y;
			w_q     <= (action == ACT_SET) ? 8'd1 : width;
			h_q     <= (action == ACT_SET) ? 8'd1 : height;
			pct_q   <= pct_clamped;
			rd_ok_q <= (32'(byte_index) < 32'(STORE_BYTES));
		end
		if (state_q == ST_CALC) begin
			prod_q <= 15'(8'(w_q - 8'd2)) * 15'(pct_q);
		end
		if (state_q == ST_SCALE) begin
			fill_q <= 8'((30'(prod_q) * 30'(RECIP)) >> RECIP_SHIFT);
		end
		addr_s1 <= addr_q;
		mask_s1 <= sweep_mask;
		full_s1 <= (act_q == ACT_FILL);
	end

	assign rd_addr = (state_q == ST_IDLE) ? ADDR_W'(byte_index) : addr_q;
	assign wr_data = full_s1 ? {8{on_q}} :
		(on_q ? (rdata_q | mask_s1) : (rdata_q & ~mask_s1));

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem[addr_s1] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

`include "page_framebuffer_draw_engine_assert.svh"

	`PFDE_ASSERT_IMP(a_no_done_clear, clr_q, !done_q, "result during clearing pass")
	`PFDE_ASSERT_IMP(a_wr_in_range, valid_s1, 32'(addr_s1) < 32'(STORE_BYTES), "write beyond store")
	`PFDE_ASSERT_IMP(a_idle_quiet, state_q == ST_IDLE, !valid_s1, "write pending while idle")
	`PFDE_ASSERT_NXT(a_rd_path, accept && (action == ACT_READ), state_q == ST_RDOUT, "read not issued")
	`PFDE_ASSERT_NXT(a_sweep_end, (state_q == ST_SWEEP) && sweep_last, valid_s1 && (state_q == ST_FINISH), "sweep end lost")

endmodule
